// ===== src/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// aps_pkg
// shared types, constants and helpers for the alpn protocol select unit
// ----------------------------------------------------------------------------
package aps_pkg;

    // fixed register file shape
    localparam int NAME_SLOTS     = 4;
    localparam int NAME_BYTES     = 8;
    localparam int NAME_W         = NAME_BYTES * 8;
    localparam int LENGTHS_W      = 16;
    localparam int COUNT_W        = 3;
    localparam int CFG_INDEX_W    = 3;

    // options in use and longest name that may match
    localparam int NUM_OPTIONS    = 4;
    localparam int MAX_NAME_BYTES = 8;

    // default limit on complete names in one list
    localparam int MAX_TOKENS_DEF = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OPTION0_NAME   = 3'd0,
        CFG_OPTION1_NAME   = 3'd1,
        CFG_OPTION2_NAME   = 3'd2,
        CFG_OPTION3_NAME   = 3'd3,
        CFG_OPTION_LENGTHS = 3'd4,
        CFG_OPTION_COUNT   = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [NAME_SLOTS-1:0][NAME_W-1:0] names;
        logic [LENGTHS_W-1:0]              lengths;
        logic [COUNT_W-1:0]                count;
    } t_cfg;

    typedef struct packed {
        logic                  awaiting;
        logic [7:0]            token_length;
        logic [7:0]            token_offset;
        logic [NAME_SLOTS-1:0] alive;
        logic                  overflow;
        logic                  match_found;
        logic [1:0]            match_index;
    } t_stream;

    localparam t_stream STREAM_RESET = '{awaiting: 1'b1, default: '0};

    typedef struct packed {
        logic       acknowledged;
        logic [1:0] option_index;
        logic [3:0] selected_length;
    } t_result;

    // 4-bit length field of option k
    function automatic logic [3:0] opt_len(input logic [LENGTHS_W-1:0] lengths,
                                           input logic [1:0] k);
        return lengths[{k, 2'b00} +: 4];
    endfunction

endpackage

// ===== src/aps_if.sv =====
// ----------------------------------------------------------------------------
// aps interfaces
// valid/ready channels for list bytes, results and register writes
// ----------------------------------------------------------------------------
interface aps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] list_byte;
    logic       is_last;
    logic       list_empty;

    modport source (output valid, list_byte, is_last, list_empty, input ready);
    modport sink   (input valid, list_byte, is_last, list_empty, output ready);
endinterface

interface aps_out_if;
    logic       valid;
    logic       ready;
    logic       acknowledged;
    logic [1:0] option_index;
    logic [3:0] selected_length;

    modport source (output valid, acknowledged, option_index, selected_length,
                    input ready);
    modport sink   (input valid, acknowledged, option_index, selected_length,
                    output ready);
endinterface

interface aps_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [aps_pkg::CFG_INDEX_W-1:0] index;
    logic [aps_pkg::NAME_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/aps_step.sv =====
// ----------------------------------------------------------------------------
// aps_step
// one list byte: length decode, parallel name compare, selection and verdict
// ----------------------------------------------------------------------------
module aps_step #(
    parameter int MAX_TOKENS = aps_pkg::MAX_TOKENS_DEF,
    parameter int CNT_W      = $clog2(MAX_TOKENS + 1)
) (
    input  aps_pkg::t_cfg    i_cfg,
    input  aps_pkg::t_stream i_state,
    input  logic [CNT_W-1:0] i_count,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_empty,
    output aps_pkg::t_stream o_state,
    output logic [CNT_W-1:0] o_count,
    output logic             o_has_result,
    output aps_pkg::t_result o_result
);

    logic [aps_pkg::COUNT_W-1:0]    used;
    logic [aps_pkg::NAME_SLOTS-1:0] alive;
    logic [3:0]                     len;
    logic [7:0]                     name_byte;
    logic [7:0]                     off_next;
    logic [1:0]                     first;
    logic                           finish;

    always_comb begin
        o_state      = i_state;
        o_count      = i_count;
        o_has_result = 1'b0;
        o_result     = '0;
        alive        = i_state.alive;
        finish       = 1'b0;
        first        = '0;
        len          = '0;
        name_byte    = '0;
        off_next     = '0;
        used = (i_cfg.count > aps_pkg::COUNT_W'(aps_pkg::NUM_OPTIONS))
             ? aps_pkg::COUNT_W'(aps_pkg::NUM_OPTIONS) : i_cfg.count;

        if (i_empty) begin
            // empty list, or a list dropped mid-stream
            o_state      = aps_pkg::STREAM_RESET;
            o_count      = '0;
            o_has_result = 1'b1;
        end else begin
            if (i_state.awaiting) begin
                alive = '0;
                for (int k = 0; k < aps_pkg::NAME_SLOTS; k++) begin
                    len = aps_pkg::opt_len(i_cfg.lengths, 2'(k));
                    if (aps_pkg::COUNT_W'(k) < used && {4'b0000, len} == i_byte
                        && len <= 4'(aps_pkg::MAX_NAME_BYTES)) begin
                        alive[k] = 1'b1;
                    end
                end
                o_state.token_length = i_byte;
                o_state.token_offset = '0;
                o_state.awaiting     = 1'b0;
                finish               = (i_byte == 8'd0);
            end else begin
                for (int k = 0; k < aps_pkg::NAME_SLOTS; k++) begin
                    name_byte = i_cfg.names[k][{i_state.token_offset[2:0], 3'b000} +: 8];
                    if (alive[k] && (i_state.token_offset >= 8'(aps_pkg::NAME_BYTES)
                                     || name_byte != i_byte)) begin
                        alive[k] = 1'b0;
                    end
                end
                off_next             = i_state.token_offset + 8'd1;
                o_state.token_offset = off_next;
                finish               = (off_next == i_state.token_length);
            end
            o_state.alive = alive;

            // lowest surviving option wins
            for (int k = aps_pkg::NAME_SLOTS - 1; k >= 0; k--) begin
                if (alive[k]) begin
                    first = 2'(k);
                end
            end

            if (finish) begin
                if (i_count < CNT_W'(MAX_TOKENS)) begin
                    o_count = i_count + CNT_W'(1);
                    if (!i_state.match_found && alive != '0) begin
                        o_state.match_found = 1'b1;
                        o_state.match_index = first;
                    end
                end else begin
                    o_state.overflow = 1'b1;
                end
                o_state.awaiting = 1'b1;
                o_state.alive    = '0;
            end

            if (i_last) begin
                o_has_result = 1'b1;
                if (o_state.match_found && !o_state.overflow) begin
                    o_result.acknowledged    = 1'b1;
                    o_result.option_index    = o_state.match_index;
                    o_result.selected_length =
                        aps_pkg::opt_len(i_cfg.lengths, o_state.match_index);
                end
                o_state = aps_pkg::STREAM_RESET;
                o_count = '0;
            end
        end
    end

endmodule

// ===== src/alpn_protocol_select_unit.sv =====
// ----------------------------------------------------------------------------
// alpn_protocol_select_unit
// server-side alpn choice over the client's length-prefixed protocol list
// ----------------------------------------------------------------------------
// The client list enters one byte per beat on i_in and is consumed at one beat
// per clock, stalling when a list-ending byte meets a full, unread result slot;
// each list's single result leaves on o_out via the input register, then the
// result register. Every byte is handled by the name compare stage, which checks
// the byte against all four server names at once, so back-to-back lists run at
// full rate while the sink keeps up. A result is given only at the last byte (or
// at an empty-list beat): acknowledged with the option index and name length of
// the first client name that equals a configured name, lowest option first on a
// tie, else NOACK with zero fields. More than MAX_TOKENS complete names forces
// NOACK. Server names and lengths are written on i_cfg (index 0..3 names, 4
// lengths, 5 count) while no list is in flight; the write port is always ready.
// ----------------------------------------------------------------------------
module alpn_protocol_select_unit #(
    parameter int MAX_TOKENS = aps_pkg::MAX_TOKENS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aps_in_if.sink    i_in,
    aps_cfg_if.sink   i_cfg,
    aps_out_if.source o_out
);

    localparam int CNT_W = $clog2(MAX_TOKENS + 1);

    // register file
    aps_pkg::t_cfg    r_cfg;

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             r_in_empty;

    // stream state
    aps_pkg::t_stream r_state;
    logic [CNT_W-1:0] r_count;

    // result register
    logic             r_out_valid;
    aps_pkg::t_result r_out;

    aps_pkg::t_stream n_state;
    logic [CNT_W-1:0] n_count;
    aps_pkg::t_result w_result;
    logic             w_has_result;
    logic             w_advance;
    logic             w_in_take;

    // register writes, always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (aps_pkg::t_cfg_reg'(i_cfg.index))
                aps_pkg::CFG_OPTION0_NAME:   r_cfg.names[0] <= i_cfg.data;
                aps_pkg::CFG_OPTION1_NAME:   r_cfg.names[1] <= i_cfg.data;
                aps_pkg::CFG_OPTION2_NAME:   r_cfg.names[2] <= i_cfg.data;
                aps_pkg::CFG_OPTION3_NAME:   r_cfg.names[3] <= i_cfg.data;
                aps_pkg::CFG_OPTION_LENGTHS: r_cfg.lengths  <= i_cfg.data[aps_pkg::LENGTHS_W-1:0];
                aps_pkg::CFG_OPTION_COUNT:   r_cfg.count    <= i_cfg.data[aps_pkg::COUNT_W-1:0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // the held byte moves on unless it carries a result and the slot is full and not read
    assign w_advance = r_in_valid && (!w_has_result || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte  <= i_in.list_byte;
            r_in_last  <= i_in.is_last;
            r_in_empty <= i_in.list_empty;
        end
    end

    aps_step #(
        .MAX_TOKENS (MAX_TOKENS),
        .CNT_W      (CNT_W)
    ) u_step (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_count      (r_count),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_empty      (r_in_empty),
        .o_state      (n_state),
        .o_count      (n_count),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aps_pkg::STREAM_RESET;
            r_count <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.acknowledged    = r_out.acknowledged;
    assign o_out.option_index    = r_out.option_index;
    assign o_out.selected_length = r_out.selected_length;

    // a new result beat only comes from a byte that finished its list
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance && w_has_result))
        else $error("result beat without a finishing byte");

    // noack beats carry zero fields
    a_noack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.acknowledged)
            |-> (r_out.option_index == 2'd0 && r_out.selected_length == 4'd0))
        else $error("noack beat with non-zero fields");

    // stream state is back at reset after each list
    a_stream_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_advance && w_has_result)
            |-> (r_state == aps_pkg::STREAM_RESET && r_count == '0))
        else $error("stream state not cleared after a list");

    // name counter saturates at the limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TOKENS))
        else $error("name counter past its limit");

    // candidate options exist only while a name body is pending
    a_alive_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.awaiting |-> (r_state.alive == '0))
        else $error("candidates left while awaiting a length byte");

endmodule

// ===== verif/alpn_protocol_select_unit_tb.sv =====
// ----------------------------------------------------------------------------
// alpn_protocol_select_unit_tb
// self-checking bench for the alpn protocol select unit
// ----------------------------------------------------------------------------
// Client protocol lists are driven into the unit one byte per beat while a
// behavioural model of the selection logic works out the answer each list
// should get. Every answer beat is compared field by field with the oldest
// prediction. Server option settings are reloaded between test phases while
// the unit is idle. Source gaps and sink stalls follow three idling profiles,
// and one long sink hold-off backs the unit up until it refuses bytes.
// ----------------------------------------------------------------------------
module alpn_protocol_select_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import aps_pkg::*;

    // limit on complete names per list, as built into the unit by default
    localparam int NAME_LIMIT  = MAX_TOKENS_DEF;
    // cycles to let pass after the last answer before touching the registers
    localparam int PIPE_SLACK  = 4;
    // cycles with no beat on any channel before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // length of the long sink hold-off
    localparam int HOLD_CYCLES = 300;

    // sample server names, byte 0 in the lowest bits
    localparam logic [63:0] H2_NAME     = 64'h0000_0000_0000_3268;
    localparam logic [63:0] HTTP11_NAME = 64'h312E_312F_7074_7468;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    aps_in_if  in_bus ();
    aps_out_if out_bus ();
    aps_cfg_if cfg_bus ();

    alpn_protocol_select_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // behavioural copy of the server options and the list parser
    // ------------------------------------------------------------------------
    logic [63:0] opt_name [NAME_SLOTS];
    logic [15:0] opt_lengths = '0;
    logic [2:0]  opt_count   = '0;

    logic       want_len   = 1'b1;  // next byte is a name length
    logic [7:0] cur_len    = '0;
    logic [7:0] cur_pos    = '0;
    logic [3:0] live       = '0;    // options still equal to the name so far
    logic [6:0] names_done = '0;
    logic       too_many   = 1'b0;
    logic       hit        = 1'b0;
    logic [1:0] hit_idx    = '0;

    // answers still owed by the unit, oldest first
    t_result expected_answers [$];

    // bytes of the list being built for sending
    logic [7:0] list_bytes [$];

    // idling controls shared with the sink process
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_left     = 0;

    int fail_count     = 0;
    int beats_sent     = 0;
    int lists_sent     = 0;
    int settings_count = 0;
    int acks_seen      = 0;
    int noacks_seen    = 0;
    int quiet_cycles   = 0;

    initial begin
        for (int k = 0; k < NAME_SLOTS; k++)
            opt_name[k] = '0;
    end

    function automatic logic [3:0] option_len(input int k);
        return opt_lengths[4*k +: 4];
    endfunction

    task automatic clear_list();
        want_len   = 1'b1;
        cur_len    = '0;
        cur_pos    = '0;
        live       = '0;
        names_done = '0;
        too_many   = 1'b0;
        hit        = 1'b0;
        hit_idx    = '0;
    endtask

    // a name is complete: count it and keep the first hit of the list
    task automatic close_name();
        if (names_done < NAME_LIMIT) begin
            names_done++;
            if (!hit && live != '0) begin
                hit = 1'b1;
                // lowest live option wins a tie
                for (int k = NUM_OPTIONS - 1; k >= 0; k--)
                    if (live[k]) hit_idx = 2'(k);
            end
        end else begin
            too_many = 1'b1;
        end
        want_len = 1'b1;
        live     = '0;
    endtask

    task automatic predict_answer(input logic [7:0] b, input logic last,
                                  input logic empty, output bit produces,
                                  output t_result res);
        int used;
        logic [7:0] nb;
        produces = 1'b0;
        res      = '0;
        if (empty) begin
            // empty list, or a list dropped part way: plain NOACK
            clear_list();
            produces = 1'b1;
        end else begin
            used = (opt_count > NUM_OPTIONS) ? NUM_OPTIONS : int'(opt_count);
            if (want_len) begin
                cur_len = b;
                cur_pos = '0;
                live    = '0;
                for (int k = 0; k < NUM_OPTIONS; k++)
                    if (k < used && 8'(option_len(k)) == b
                            && option_len(k) <= MAX_NAME_BYTES)
                        live[k] = 1'b1;
                want_len = 1'b0;
                // a zero length byte is a whole empty name
                if (b == 8'd0)
                    close_name();
            end else begin
                for (int k = 0; k < NUM_OPTIONS; k++) begin
                    if (live[k]) begin
                        nb = opt_name[k][8*cur_pos[2:0] +: 8];
                        if (cur_pos >= 8'd8 || nb != b)
                            live[k] = 1'b0;
                    end
                end
                cur_pos = cur_pos + 8'd1;
                if (cur_pos == cur_len)
                    close_name();
            end
            // a name still open here is simply dropped
            if (last) begin
                if (hit && !too_many) begin
                    res.acknowledged    = 1'b1;
                    res.option_index    = hit_idx;
                    res.selected_length = option_len(hit_idx);
                end
                clear_list();
                produces = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // list byte source
    // ------------------------------------------------------------------------
    // valid stays high between back-to-back beats; it only drops for a gap
    task automatic push_byte(input logic [7:0] b, input logic last, input logic empty);
        bit produces;
        t_result res;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            in_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_bus.valid      <= 1'b1;
        in_bus.list_byte  <= b;
        in_bus.is_last    <= last;
        in_bus.list_empty <= empty;
        do @(posedge i_clk); while (!in_bus.ready);
        predict_answer(b, last, empty, produces, res);
        if (produces)
            expected_answers.push_back(res);
        beats_sent++;
    endtask

    task automatic send_list(input bit close_with_last);
        int n;
        n = list_bytes.size();
        for (int j = 0; j < n; j++)
            push_byte(list_bytes[j], close_with_last && (j == n - 1), 1'b0);
        list_bytes.delete();
    endtask

    // length byte then the name; bytes past the eighth are random
    task automatic append_name(input int len, input logic [63:0] src);
        list_bytes.push_back(8'(len));
        for (int j = 0; j < len; j++)
            list_bytes.push_back(j < 8 ? src[8*j +: 8] : 8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // register writes, only ever with the unit idle
    // ------------------------------------------------------------------------
    task automatic settle();
        in_bus.valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge i_clk);
        // a trailing byte with no answer may still be in the pipe
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [63:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CFG_OPTION0_NAME:   opt_name[0] = value;
            CFG_OPTION1_NAME:   opt_name[1] = value;
            CFG_OPTION2_NAME:   opt_name[2] = value;
            CFG_OPTION3_NAME:   opt_name[3] = value;
            CFG_OPTION_LENGTHS: opt_lengths = value[15:0];
            CFG_OPTION_COUNT:   opt_count   = value[2:0];
            default: ;
        endcase
    endtask

    task automatic load_options(input logic [3:0][63:0] names,
                                input logic [63:0] lengths_word,
                                input logic [63:0] count_word);
        settle();
        write_reg(CFG_OPTION0_NAME, names[0]);
        write_reg(CFG_OPTION1_NAME, names[1]);
        write_reg(CFG_OPTION2_NAME, names[2]);
        write_reg(CFG_OPTION3_NAME, names[3]);
        write_reg(CFG_OPTION_LENGTHS, lengths_word);
        write_reg(CFG_OPTION_COUNT, count_word);
        cfg_bus.valid <= 1'b0;
        settings_count++;
    endtask

    // random names with some exact copies so that ties happen; lengths
    // mostly legal, now and then above the longest name that can match
    task automatic random_options();
        logic [3:0][63:0] names;
        logic [15:0] lens;
        logic [47:0] junk;
        for (int k = 0; k < NAME_SLOTS; k++) begin
            names[k] = {$urandom, $urandom};
            lens[4*k +: 4] = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 8));
            if (k > 0 && $urandom_range(3) == 0) begin
                names[k] = names[k-1];
                lens[4*k +: 4] = lens[4*(k-1) +: 4];
            end
        end
        junk = $urandom_range(1) ? {$urandom, 16'($urandom)} : '0;
        load_options(names, {junk, lens},
                     $urandom_range(9) < 6 ? 64'd4 : 64'($urandom_range(0, 7)));
    endtask

    // ------------------------------------------------------------------------
    // random list shapes
    // ------------------------------------------------------------------------
    task automatic send_random_list();
        int kind;
        int tail;
        int k;
        int len;
        int pick;
        int n;
        logic [63:0] src;
        kind = $urandom_range(99);
        lists_sent++;
        if (kind < 5) begin
            // lone empty-list beat with junk in the other fields
            push_byte(8'($urandom), 1'($urandom_range(1)), 1'b1);
        end else if (kind < 12) begin
            // noise: raw bytes with no regard for the length prefixes
            n = $urandom_range(1, 12);
            repeat (n) list_bytes.push_back(8'($urandom));
            send_list(1'b1);
        end else begin
            repeat ($urandom_range(1, 6)) begin
                pick = $urandom_range(99);
                k    = $urandom_range(NAME_SLOTS - 1);
                len  = option_len(k);
                src  = opt_name[k];
                if (pick >= 72) begin
                    len = $urandom_range(0, 10);
                    src = {$urandom, $urandom};
                end else if (pick >= 55 && len > 0) begin
                    // near miss: one byte of a server name flipped
                    n   = $urandom_range(len - 1) % 8;
                    src = src ^ (64'($urandom_range(1, 255)) << (8 * n));
                end
                append_name(len, src);
            end
            tail = $urandom_range(99);
            if (tail < 12) begin
                // name cut short by the end of the list
                len = $urandom_range(1, 12);
                list_bytes.push_back(8'(len));
                repeat ($urandom_range(0, len - 1)) list_bytes.push_back(8'($urandom));
                send_list(1'b1);
            end else if (tail < 18) begin
                // list abandoned with an empty-list beat
                send_list(1'b0);
                push_byte(8'($urandom), 1'($urandom_range(1)), 1'b1);
            end else begin
                send_list(1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // answer sink and checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (hold_left > 0) begin
            out_bus.ready <= 1'b0;
            hold_left--;
        end else begin
            out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_answers.size() == 0) begin
                $error("answer beat with no list pending: ack %0d index %0d length %0d",
                       out_bus.acknowledged, out_bus.option_index,
                       out_bus.selected_length);
                fail_count++;
            end else begin
                want = expected_answers.pop_front();
                if (out_bus.acknowledged !== want.acknowledged) begin
                    $error("acknowledged: expected %0d, got %0d",
                           want.acknowledged, out_bus.acknowledged);
                    fail_count++;
                end
                if (out_bus.option_index !== want.option_index) begin
                    $error("option_index: expected %0d, got %0d",
                           want.option_index, out_bus.option_index);
                    fail_count++;
                end
                if (out_bus.selected_length !== want.selected_length) begin
                    $error("selected_length: expected %0d, got %0d",
                           want.selected_length, out_bus.selected_length);
                    fail_count++;
                end
            end
            if (out_bus.acknowledged === 1'b1)
                acks_seen++;
            else
                noacks_seen++;
        end
    end

    // hang detector: any beat on any channel restarts the count
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no beat for %0d cycles, %0d answers outstanding",
                     STALL_LIMIT, expected_answers.size());
            $display("FAIL alpn_protocol_select_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // straight out of reset no option is in use, so everything is NOACK
    task automatic test_reset_options();
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b1);
        lists_sent += 2;
    endtask

    task automatic test_directed();
        // h2 twice for a tie, an empty name, and a nine byte option that
        // can never match; count above the number of slots
        load_options({HTTP11_NAME, ALL_ONES, H2_NAME, H2_NAME}, 64'h9022, 64'd7);
        push_byte(8'hFF, 1'b1, 1'b1);          // empty list
        push_byte(8'h00, 1'b1, 1'b0);          // empty name hits option 2
        append_name(2, H2_NAME);               // tie goes to option 0
        send_list(1'b1);
        // client order first: empty name before h2, then a cut-off name
        append_name(0, '0);
        append_name(2, H2_NAME);
        list_bytes.push_back(8'h05);
        list_bytes.push_back(8'h78);
        send_list(1'b1);
        append_name(2, H2_NAME);               // dropped part way through
        list_bytes.pop_back();
        send_list(1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b0);          // longest length, nothing follows
        append_name(9, HTTP11_NAME);           // over-long option never matches
        send_list(1'b1);
        lists_sent += 7;
    endtask

    task automatic test_random_lists(input int beats);
        int start;
        start = beats_sent;
        while (beats_sent - start < beats)
            send_random_list();
    endtask

    // lists of empty names either side of the name limit
    task automatic test_name_limit();
        load_options('0, 64'h0, 64'd1);
        for (int n = NAME_LIMIT - 1; n <= NAME_LIMIT + 2; n++) begin
            repeat (n) list_bytes.push_back(8'h00);
            send_list(1'b1);
            lists_sent++;
        end
        repeat (2) begin
            repeat ($urandom_range(NAME_LIMIT - 4, NAME_LIMIT + 4))
                list_bytes.push_back(8'h00);
            send_list(1'b1);
            lists_sent++;
        end
    endtask

    // sink holds off while one-beat lists keep coming, so the unit fills
    task automatic test_backpressure();
        logic [3:0][63:0] names;
        for (int k = 0; k < NAME_SLOTS; k++)
            names[k] = {$urandom, $urandom};
        load_options(names, ALL_ONES, 64'd0);
        hold_left = HOLD_CYCLES;
        repeat (60) begin
            if ($urandom_range(1))
                push_byte(8'h00, 1'b1, 1'b0);
            else
                push_byte(8'($urandom), 1'($urandom_range(1)), 1'b1);
            lists_sent++;
        end
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.list_byte  = '0;
        in_bus.is_last    = 1'b0;
        in_bus.list_empty = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = CFG_OPTION0_NAME;
        cfg_bus.data      = '0;
        out_bus.ready     = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(20, 59);
        test_reset_options();
        test_directed();
        random_options();
        test_random_lists(330);

        set_idling(59, 20);
        // all-ones names at full length
        load_options({ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES}, 64'h8888, 64'd7);
        test_random_lists(330);

        set_idling(0, 0);
        random_options();
        test_random_lists(330);
        // all names empty, junk in the unused register bits
        load_options('0, 64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFFC);
        test_random_lists(330);
        test_name_limit();
        test_backpressure();

        settle();
        if (expected_answers.size() != 0) begin
            $error("%0d answers never arrived", expected_answers.size());
            fail_count++;
        end
        $display("%0d list beats in %0d lists, %0d answers checked (%0d ack, %0d NOACK)",
                 beats_sent, lists_sent, acks_seen + noacks_seen, acks_seen,
                 noacks_seen);
        $display("%0d option settings loaded, %0d failures", settings_count,
                 fail_count);
        if (fail_count == 0)
            $display("PASS alpn_protocol_select_unit");
        else
            $display("FAIL alpn_protocol_select_unit");
        $finish;
    end

endmodule
